// ===== design/pita_pkg.sv =====
`timescale 1ns / 1ps
package pita_pkg;

  localparam int CW   = 16;                    // coordinate width
  localparam int EW   = CW + 1;                // edge component width
  localparam int PW   = 2 * EW;                // edge product width
  localparam int XW   = PW + 1;                // cross component width
  localparam int HL   = XW / 2;                // low half for split square
  localparam int HH   = XW - HL;               // high half for split square
  localparam int SW   = 2 * XW + 2;            // squared length width
  localparam int RW   = SW / 2;                // root width
  localparam int RMW  = RW + 2;                // root remainder width
  localparam int TW   = 36;                    // tolerance width
  localparam int ASW  = RW + 2;                // width of the sub-area sum
  localparam int CMPW = ((RW > TW) ? RW : TW) + 2;
  localparam int XLAT = 7;                     // stages in the cross unit

  localparam logic [TW-1:0] TOL_RESET = TW'(16);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [EW-1:0] edge_t;
  typedef logic [TW-1:0]        tol_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } pt_t;

  typedef struct packed {
    edge_t x;
    edge_t y;
    edge_t z;
  } vec_t;

endpackage

// ===== design/pita_in_if.sv =====
`timescale 1ns / 1ps
interface pita_in_if;
  import pita_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  coord_t vertex0_x;
  coord_t vertex0_y;
  coord_t vertex0_z;
  coord_t vertex1_x;
  coord_t vertex1_y;
  coord_t vertex1_z;
  coord_t vertex2_x;
  coord_t vertex2_y;
  coord_t vertex2_z;
  modport source (output valid, point_x, point_y, point_z, vertex0_x, vertex0_y, vertex0_z,
                  vertex1_x, vertex1_y, vertex1_z, vertex2_x, vertex2_y, vertex2_z,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, vertex0_x, vertex0_y, vertex0_z,
                vertex1_x, vertex1_y, vertex1_z, vertex2_x, vertex2_y, vertex2_z,
                output ready);
endinterface

// ===== design/pita_out_if.sv =====
`timescale 1ns / 1ps
interface pita_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

// ===== design/pita_cfg_if.sv =====
`timescale 1ns / 1ps
interface pita_cfg_if;
  import pita_pkg::*;
  logic valid;
  logic ready;
  tol_t area_tolerance;
  modport source (output valid, area_tolerance, input ready);
  modport sink (input valid, area_tolerance, output ready);
endinterface

// ===== design/pita_cross.sv =====
`timescale 1ns / 1ps
module pita_cross (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  pita_pkg::pt_t        pa,
  input  pita_pkg::pt_t        pb,
  input  pita_pkg::pt_t        pc,
  output logic                 out_valid,
  output logic [pita_pkg::SW-1:0] sq
);
  import pita_pkg::*;

  logic [XLAT-1:0] v_r;

  vec_t e1_r, e2_r;
  logic signed [PW-1:0] p_r [6];
  logic signed [XW-1:0] c_r [3];
  logic [XW-1:0]        m_r [3];
  logic [2*HH-1:0]      hh_r [3];
  logic [HH+HL-1:0]     hl_r [3];
  logic [2*HL-1:0]      ll_r [3];
  logic [2*XW-1:0]      q_r [3];
  logic [SW-1:0]        s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[XLAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // edges from the first corner
      e1_r.x <= EW'(pb.x) - EW'(pa.x);
      e1_r.y <= EW'(pb.y) - EW'(pa.y);
      e1_r.z <= EW'(pb.z) - EW'(pa.z);
      e2_r.x <= EW'(pc.x) - EW'(pa.x);
      e2_r.y <= EW'(pc.y) - EW'(pa.y);
      e2_r.z <= EW'(pc.z) - EW'(pa.z);
      // cross product terms
      p_r[0] <= PW'(e1_r.y) * PW'(e2_r.z);
      p_r[1] <= PW'(e1_r.z) * PW'(e2_r.y);
      p_r[2] <= PW'(e1_r.z) * PW'(e2_r.x);
      p_r[3] <= PW'(e1_r.x) * PW'(e2_r.z);
      p_r[4] <= PW'(e1_r.x) * PW'(e2_r.y);
      p_r[5] <= PW'(e1_r.y) * PW'(e2_r.x);
      for (int k = 0; k < 3; k++) begin
        c_r[k]  <= XW'(p_r[2*k]) - XW'(p_r[2*k+1]);
        m_r[k]  <= c_r[k][XW-1] ? XW'(-c_r[k]) : XW'(c_r[k]);
        hh_r[k] <= (2*HH)'(m_r[k][XW-1:HL]) * (2*HH)'(m_r[k][XW-1:HL]);
        hl_r[k] <= (HH+HL)'(m_r[k][XW-1:HL]) * (HH+HL)'(m_r[k][HL-1:0]);
        ll_r[k] <= (2*HL)'(m_r[k][HL-1:0]) * (2*HL)'(m_r[k][HL-1:0]);
        q_r[k]  <= ((2*XW)'(hh_r[k]) << (2*HL)) + ((2*XW)'(hl_r[k]) << (HL+1))
                   + (2*XW)'(ll_r[k]);
      end
      s_r <= SW'(q_r[0]) + SW'(q_r[1]) + SW'(q_r[2]);
    end
  end

  assign out_valid = v_r[XLAT-1];
  assign sq        = s_r;

endmodule

// ===== design/pita_isqrt.sv =====
`timescale 1ns / 1ps
module pita_isqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic [pita_pkg::SW-1:0] n,
  output logic                    out_valid,
  output logic [pita_pkg::RW-1:0] root
);
  import pita_pkg::*;

  logic           v_r    [RW];
  logic [SW-1:0]  n_r    [RW];
  logic [RMW-1:0] rem_r  [RW];
  logic [RW-1:0]  root_r [RW];

  // one root bit per stage
  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic           v_in;
    logic [SW-1:0]  n_in;
    logic [RMW-1:0] rem_in;
    logic [RW-1:0]  root_in;
    logic [RMW-1:0] remsh;
    logic [RMW-1:0] trial;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign n_in    = n;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign n_in    = n_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    assign remsh = {rem_in[RMW-3:0], n_in[SW-1:SW-2]};
    assign trial = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        n_r[i] <= n_in << 2;
        if (remsh >= trial) begin
          rem_r[i]  <= remsh - trial;
          root_r[i] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_r[i]  <= remsh;
          root_r[i] <= {root_in[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign root      = root_r[RW-1];

endmodule

// ===== design/point_in_triangle_area_test_core.sv =====
`timescale 1ns / 1ps
// point in triangle test by area sums, 3d, signed fixed point coordinates.
// each input beat carries a point p and vertices v0, v1, v2; the block forms
// the doubled area of the triangle and of (p,v0,v1), (p,v1,v2), (p,v2,v0) as
// the floored integer root of the squared cross product length, and reports
// inside_res = 1 when the three sub-areas sum to no more than the triangle
// area plus area_tolerance. one beat is accepted per cycle while the output
// is not stalled; a result passes through the cross/square pipeline, the
// one-bit-per-stage square root pipeline, the sum register and the output
// register. a stall at the output freezes the whole pipeline and holds
// in_if.ready low. area_tolerance may be written at any time the block is
// idle; cfg_if.ready is always high.
module point_in_triangle_area_test_core (
  input  logic        clk,
  input  logic        rst_n,
  pita_in_if.sink     in_if,
  pita_out_if.source  out_if,
  pita_cfg_if.sink    cfg_if
);
  import pita_pkg::*;

  pt_t p, v0, v1, v2;
  logic adv;

  tol_t tol_r;

  logic          xv   [4];
  logic [SW-1:0] xsq  [4];
  logic          rv   [4];
  logic [RW-1:0] rt   [4];

  logic           sv_r;
  logic [ASW-1:0] sum_r;
  logic [RW-1:0]  tot_r;

  logic out_valid_r;
  logic inside_r;

  // the whole pipeline moves whenever the output register can take a beat
  assign adv          = !out_valid_r || out_if.ready;
  assign in_if.ready  = adv;
  assign cfg_if.ready = 1'b1;

  assign p  = '{x: in_if.point_x,   y: in_if.point_y,   z: in_if.point_z};
  assign v0 = '{x: in_if.vertex0_x, y: in_if.vertex0_y, z: in_if.vertex0_z};
  assign v1 = '{x: in_if.vertex1_x, y: in_if.vertex1_y, z: in_if.vertex1_z};
  assign v2 = '{x: in_if.vertex2_x, y: in_if.vertex2_y, z: in_if.vertex2_z};

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_if.valid) begin
      tol_r <= cfg_if.area_tolerance;
    end
  end

  // triangle, then the three sub-triangles around the point
  pita_cross u_x0 (.clk, .rst_n, .adv, .in_valid(in_if.valid),
                   .pa(v0), .pb(v1), .pc(v2), .out_valid(xv[0]), .sq(xsq[0]));
  pita_cross u_x1 (.clk, .rst_n, .adv, .in_valid(in_if.valid),
                   .pa(p), .pb(v0), .pc(v1), .out_valid(xv[1]), .sq(xsq[1]));
  pita_cross u_x2 (.clk, .rst_n, .adv, .in_valid(in_if.valid),
                   .pa(p), .pb(v1), .pc(v2), .out_valid(xv[2]), .sq(xsq[2]));
  pita_cross u_x3 (.clk, .rst_n, .adv, .in_valid(in_if.valid),
                   .pa(p), .pb(v2), .pc(v0), .out_valid(xv[3]), .sq(xsq[3]));

  for (genvar k = 0; k < 4; k++) begin : g_root
    pita_isqrt u_rt (.clk, .rst_n, .adv, .in_valid(xv[k]), .n(xsq[k]),
                     .out_valid(rv[k]), .root(rt[k]));
  end

  // sub-area sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
    end else if (adv) begin
      sv_r <= rv[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= ASW'(rt[1]) + ASW'(rt[2]) + ASW'(rt[3]);
      tot_r <= rt[0];
    end
  end

  // compare and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inside_r <= CMPW'(sum_r) <= (CMPW'(tot_r) + CMPW'(tol_r));
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.inside_res = inside_r;

endmodule

// ===== design/pita_checker.sv =====
`timescale 1ns / 1ps
module pita_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic inside_res
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(inside_res))
    else $error("result dropped or changed under stall");

  // no intake while the output is stalled
  a_no_take_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // free output means the block takes a beat
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked with free output");

  // no result appears right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

endmodule

bind point_in_triangle_area_test_core pita_checker u_pita_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .inside_res (out_if.inside_res)
);
